[src/cmfs_pkg.sv]
// Shared types, constants and arithmetic helpers for the cube map face selector.
`default_nettype none
package cmfs_pkg;

    localparam int CompBits  = 16;
    localparam int TexBits   = 16;
    localparam int QuotBits  = TexBits + 1;
    localparam int DivStages = QuotBits;
    localparam int QueueAw   = 2;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    typedef struct packed {
        logic signed [CompBits-1:0] dir_x;
        logic signed [CompBits-1:0] dir_y;
        logic signed [CompBits-1:0] dir_z;
    } t_dir;

    typedef struct packed {
        logic [2:0]         face;
        logic [TexBits-1:0] tex_u;
        logic [TexBits-1:0] tex_v;
        logic               degenerate;
    } t_result;

    // Classified request: numerators already offset by the major magnitude
    typedef struct packed {
        logic [2:0]          face;
        logic                degenerate;
        logic                u_lo;
        logic                u_hi;
        logic                v_lo;
        logic                v_hi;
        logic [CompBits-1:0] num_u;
        logic [CompBits-1:0] num_v;
        logic [CompBits-1:0] den;
    } t_job;

    typedef struct packed {
        t_job                job;
        logic [CompBits-1:0] rem_u;
        logic [CompBits-1:0] rem_v;
        logic [QuotBits-1:0] quo_u;
        logic [QuotBits-1:0] quo_v;
    } t_div;

    // One restoring step on both coordinates
    function automatic t_div div_step(input t_div s);
        t_div              o;
        logic [CompBits:0] ru;
        logic [CompBits:0] rv;
        o  = s;
        ru = {s.rem_u, 1'b0};
        rv = {s.rem_v, 1'b0};
        if (ru >= {1'b0, s.job.den}) begin
            ru = ru - {1'b0, s.job.den};
            o.quo_u = {s.quo_u[QuotBits-2:0], 1'b1};
        end else begin
            o.quo_u = {s.quo_u[QuotBits-2:0], 1'b0};
        end
        if (rv >= {1'b0, s.job.den}) begin
            rv = rv - {1'b0, s.job.den};
            o.quo_v = {s.quo_v[QuotBits-2:0], 1'b1};
        end else begin
            o.quo_v = {s.quo_v[QuotBits-2:0], 1'b0};
        end
        o.rem_u = ru[CompBits-1:0];
        o.rem_v = rv[CompBits-1:0];
        return o;
    endfunction

    // Round half up, then clamp
    function automatic logic [TexBits-1:0] round_coord(input logic [QuotBits-1:0] q,
                                                       input logic lo, input logic hi,
                                                       input logic degen);
        logic [QuotBits:0]  qr;
        logic [TexBits-1:0] c;
        qr = ({1'b0, q} + {{QuotBits{1'b0}}, 1'b1}) >> 1;
        if (qr[QuotBits:TexBits] != '0) c = '1;
        else                            c = qr[TexBits-1:0];
        if (degen)   c = {1'b1, {(TexBits-1){1'b0}}};
        else if (lo) c = '0;
        else if (hi) c = '1;
        return c;
    endfunction

endpackage
`default_nettype wire

[src/cmfs_front.sv]
// Front end: picks the major axis and face, and forms the division operands.
`default_nettype none
module cmfs_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  cmfs_pkg::t_dir    i_dir,
    output logic              o_valid,
    input  wire logic         i_ready,
    output cmfs_pkg::t_job    o_job
);
    localparam int Cb = cmfs_pkg::CompBits;

    logic                 r_valid;
    cmfs_pkg::t_job       r_job;
    cmfs_pkg::t_job       n_job;

    logic [Cb-2:0]        ax, ay, az, m;
    logic signed [Cb:0]   x, y, z, su, sv;
    logic signed [Cb+1:0] snu, snv, dd;
    logic [2:0]           face;

    function automatic logic [Cb-2:0] sat_abs(input logic signed [Cb-1:0] v);
        logic [Cb-1:0] a;
        a = v[Cb-1] ? (~v + 1'b1) : v;
        return a[Cb-1] ? {(Cb-1){1'b1}} : a[Cb-2:0];
    endfunction

    always_comb begin
        x  = {i_dir.dir_x[Cb-1], i_dir.dir_x};
        y  = {i_dir.dir_y[Cb-1], i_dir.dir_y};
        z  = {i_dir.dir_z[Cb-1], i_dir.dir_z};
        ax = sat_abs(i_dir.dir_x);
        ay = sat_abs(i_dir.dir_y);
        az = sat_abs(i_dir.dir_z);
        if (ax >= ay && ax >= az) begin
            m  = ax;
            sv = -y;
            if (!x[Cb] && x != '0) begin face = cmfs_pkg::FACE_POS_X; su = -z; end
            else                   begin face = cmfs_pkg::FACE_NEG_X; su = z;  end
        end else if (ay >= az) begin
            m  = ay;
            su = x;
            if (!y[Cb] && y != '0) begin face = cmfs_pkg::FACE_POS_Y; sv = z;  end
            else                   begin face = cmfs_pkg::FACE_NEG_Y; sv = -z; end
        end else begin
            m  = az;
            sv = -y;
            if (!z[Cb] && z != '0) begin face = cmfs_pkg::FACE_POS_Z; su = x;  end
            else                   begin face = cmfs_pkg::FACE_NEG_Z; su = -x; end
        end
        snu = {su[Cb], su} + $signed({3'b000, m});
        snv = {sv[Cb], sv} + $signed({3'b000, m});
        dd  = $signed({2'b00, m, 1'b0});

        n_job.degenerate = (x == '0) && (y == '0) && (z == '0);
        n_job.face  = n_job.degenerate ? 3'(cmfs_pkg::FACE_POS_X) : face;
        n_job.u_lo  = snu <= 0;
        n_job.v_lo  = snv <= 0;
        n_job.u_hi  = snu >= dd;
        n_job.v_hi  = snv >= dd;
        n_job.num_u = snu[Cb-1:0];
        n_job.num_v = snv[Cb-1:0];
        n_job.den   = {m, 1'b0};
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule
`default_nettype wire

[src/cmfs_queue.sv]
// Short queue between the front end and the divider pipeline.
`default_nettype none
module cmfs_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  cmfs_pkg::t_job i_job,
    output logic           o_valid,
    input  wire logic      i_ready,
    output cmfs_pkg::t_job o_job
);
    localparam int Aw    = cmfs_pkg::QueueAw;
    localparam int Depth = 1 << Aw;

    cmfs_pkg::t_job r_mem [Depth];
    logic [Aw-1:0]  r_wr, r_rd;
    logic [Aw:0]    r_cnt;
    logic           push, pop;

    assign o_ready = r_cnt != (Aw+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
        end
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end
endmodule
`default_nettype wire

[src/cmfs_back.sv]
// Back end: one quotient bit per stage for both coordinates, then rounding.
`default_nettype none
module cmfs_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  cmfs_pkg::t_job    i_job,
    output logic              o_valid,
    input  wire logic         i_ready,
    output cmfs_pkg::t_result o_result
);
    localparam int Ns = cmfs_pkg::DivStages;

    cmfs_pkg::t_div    r_st  [Ns];
    logic [Ns-1:0]     r_vld;
    logic              r_o_valid;
    cmfs_pkg::t_result r_out;
    cmfs_pkg::t_div    init;
    cmfs_pkg::t_div    last;
    logic              adv;

    assign adv     = !r_o_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_o_valid;
    assign o_result = r_out;
    assign last    = r_st[Ns-1];

    always_comb begin
        init.job   = i_job;
        init.rem_u = i_job.num_u;
        init.rem_v = i_job.num_v;
        init.quo_u = '0;
        init.quo_v = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[Ns-2:0], i_valid};
            r_o_valid <= r_vld[Ns-1];
        end
        if (adv) begin
            r_st[0] <= cmfs_pkg::div_step(init);
            for (int i = 1; i < Ns; i++) begin
                r_st[i] <= cmfs_pkg::div_step(r_st[i-1]);
            end
            r_out.face       <= last.job.face;
            r_out.degenerate <= last.job.degenerate;
            r_out.tex_u      <= cmfs_pkg::round_coord(last.quo_u, last.job.u_lo,
                                                      last.job.u_hi, last.job.degenerate);
            r_out.tex_v      <= cmfs_pkg::round_coord(last.quo_v, last.job.v_lo,
                                                      last.job.v_hi, last.job.degenerate);
        end
    end
endmodule
`default_nettype wire

[src/cube_map_face_select.sv]
// Top level of the cube map face selector: front end, queue and divider pipeline.
//
//  port group    direction  handshake                   payload
//  request in    input      i_in_valid / o_in_ready     i_in_data   (t_dir)
//  result out    output     o_out_valid / i_out_ready   o_out_data  (t_result)
//
// One request a cycle is taken and one result a cycle is given when the sink keeps up.
// A request passes the front register, the queue, 17 divide stages and the output register;
// the 17 stages each resolve one quotient bit of both coordinates.
// Reset clears all valid bits and queue pointers; no clearing pass.
// A stalled output freezes the divide pipeline; the queue absorbs the front end meanwhile.
`default_nettype none
module cube_map_face_select (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  cmfs_pkg::t_dir    i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output cmfs_pkg::t_result o_out_data
);
    logic           f_valid, f_ready, q_valid, q_ready;
    cmfs_pkg::t_job f_job, q_job;

    cmfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_dir   (i_in_data),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_job   (f_job)
    );

    cmfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    cmfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_job    (q_job),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_data)
    );
endmodule
`default_nettype wire
